// ===== design/rek_pkg.sv =====
// Shared types and constants for the rotary encoder key event scanner.
// No dependencies; every other design file imports this package.

package rek_pkg;

    // Field and register widths.
    localparam int COUNT_W = 16;
    localparam int STEP_W  = 8;
    localparam int HOLD_W  = 16;
    localparam int CFG_W   = 16;

    // Configuration register indexes.
    localparam logic CFG_PULSES_PER_STEP  = 1'b0;
    localparam logic CFG_LONG_PRESS_TICKS = 1'b1;

    // Event codes carried by each result word.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_LONG  = 3'd3,
        EV_SHORT = 3'd4
    } event_t;

    // Button machine phases.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_WAITREL  = 2'd3
    } phase_t;

    // Rotation decision handed from the step detector to the top level.
    typedef struct packed {
        logic capture;    // baseline not yet taken: this tick only captures it
        logic step_up;
        logic step_down;
    } step_info_t;

endpackage

// ===== design/rotary_encoder_key_events_core.sv =====
// Flow: an accepted word waits in the input register, and its event is loaded into
// the result register when the result slot is free or being taken.
// Throughput: one word per cycle, also while the result is taken, unless m_ready is low.
// Reset (aresetn, synchronous, active low) clears the baseline, the button machine
// and both stages, and loads step size 4 and long-press threshold 75.
// Top level of the scanner. Depends on rek_pkg, rek_step_detect, rek_button_fsm.

module rotary_encoder_key_events_core
    import rek_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COUNT_W-1:0] s_counter_value,
    input  logic               s_button_level,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_event_code
);

    logic [STEP_W-1:0]  pps_reg;
    logic [HOLD_W-1:0]  lpt_reg;
    logic               in_valid_reg;
    logic [COUNT_W-1:0] in_count_reg;
    logic               in_level_reg;
    logic               out_valid_reg;
    event_t             out_event_reg;
    event_t             event_next;
    event_t             button_event;
    step_info_t         step_info;
    logic               advance;
    logic               button_en;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pps_reg <= STEP_W'(4);
            lpt_reg <= HOLD_W'(75);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PULSES_PER_STEP:  pps_reg <= cfg_wr_data[STEP_W-1:0];
                CFG_LONG_PRESS_TICKS: lpt_reg <= cfg_wr_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: the input word moves on whenever the result slot is free or being taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_count_reg <= s_counter_value;
            in_level_reg <= s_button_level;
        end
    end

    rek_step_detect u_step_detect (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .counter_value   (in_count_reg),
        .pulses_per_step (pps_reg),
        .step_info       (step_info)
    );

    // The button is examined only on ticks without rotation or capture.
    assign button_en = advance && !step_info.capture
                       && !step_info.step_up && !step_info.step_down;

    rek_button_fsm u_button_fsm (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .enable           (button_en),
        .pressed          (!in_level_reg),
        .hold_limit       (lpt_reg),
        .button_event     (button_event)
    );

    // Event selection: capture, then rotation, then the button.
    always_comb begin
        priority if (step_info.capture) begin
            event_next = EV_NONE;
        end else if (step_info.step_up) begin
            event_next = EV_UP;
        end else if (step_info.step_down) begin
            event_next = EV_DOWN;
        end else begin
            event_next = button_event;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= event_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = out_event_reg;

    // A word that moves on always lands in the result register.
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    // Input is refused only when both stages are full and the output is stalled.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input refused while a stage was free");

    // The capture tick reports no event.
    a_capture_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_info.capture) |=> (out_event_reg == EV_NONE))
        else $error("capture tick reported an event");

    // A rotation step never runs the button machine.
    a_step_blocks_button: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_info.step_up || step_info.step_down) |-> !button_en)
        else $error("button machine ran on a rotation tick");

    // Up and down are never both detected.
    a_step_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_info.step_up && step_info.step_down))
        else $error("both step directions detected");

endmodule

// ===== design/rek_step_detect.sv =====
// Rotation step detector: holds the counter baseline and compares the wrapped
// difference against the step size. Depends on rek_pkg.

module rek_step_detect
    import rek_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [COUNT_W-1:0] counter_value,
    input  logic [STEP_W-1:0]  pulses_per_step,
    output step_info_t         step_info
);

    logic [COUNT_W-1:0] baseline_reg;
    logic               baseline_valid_reg;
    logic [COUNT_W-1:0] diff;
    logic [COUNT_W:0]   neg_mag;
    logic [STEP_W-1:0]  step_size;

    // A step size of zero behaves as one.
    assign step_size = (pulses_per_step == '0) ? STEP_W'(1) : pulses_per_step;

    // Wrapped difference; the sign bit picks which threshold applies.
    assign diff    = counter_value - baseline_reg;
    assign neg_mag = {1'b1, {COUNT_W{1'b0}}} - {1'b0, diff};

    always_comb begin
        step_info.capture   = !baseline_valid_reg;
        step_info.step_up   = baseline_valid_reg && !diff[COUNT_W-1]
                              && (diff >= COUNT_W'(step_size));
        step_info.step_down = baseline_valid_reg && diff[COUNT_W-1]
                              && (neg_mag >= (COUNT_W+1)'(step_size));
    end

    // The baseline is captured on the first tick and rebased on every step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg       <= '0;
            baseline_valid_reg <= 1'b0;
        end else if (advance) begin
            baseline_valid_reg <= 1'b1;
            if (step_info.capture || step_info.step_up || step_info.step_down) begin
                baseline_reg <= counter_value;
            end
        end
    end

endmodule

// ===== design/rek_button_fsm.sv =====
// Push-button machine: debounce, hold counting and long or short press events.
// Depends on rek_pkg.

module rek_button_fsm
    import rek_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              pressed,
    input  logic [HOLD_W-1:0] hold_limit,
    output event_t            button_event
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic [HOLD_W-1:0] hold_inc;
    logic              hold_done;

    // A threshold of zero is met by the first increment, same as one.
    assign hold_inc  = hold_reg + HOLD_W'(1);
    assign hold_done = (hold_inc >= hold_limit);

    // Next phase and hold count.
    always_comb begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (pressed) phase_next = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
                if (pressed) begin
                    phase_next = PH_PRESSED;
                    hold_next  = '0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRESSED: begin
                if (pressed) begin
                    hold_next = hold_inc;
                    if (hold_done) phase_next = PH_WAITREL;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_WAITREL: begin
                if (!pressed) phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Event output: only the pressed phase reports anything.
    always_comb begin
        button_event = EV_NONE;
        if (phase_reg == PH_PRESSED) begin
            if (!pressed) begin
                button_event = EV_SHORT;
            end else if (hold_done) begin
                button_event = EV_LONG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
        end else if (enable) begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the rotary encoder key event scanner.
// It predicts the event of each scan tick in its own model and checks each result word.
// Depends on rek_pkg and rotary_encoder_key_events_core.

module tb
    import rek_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_OFF     = 60;
    localparam int DRAIN_CYCLES = 4;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [COUNT_W-1:0] s_counter_value;
    logic               s_button_level;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_event_code;

    // Events still owed by the block, oldest first.
    event_t expected_events[$];

    // Predicted scanner state and settings.
    logic [15:0] base_count;
    logic        base_taken;
    phase_t      btn_phase;
    logic [15:0] hold_ticks;
    logic [7:0]  step_pulses;
    logic [15:0] long_ticks;

    int errors = 0;
    int cycles = 0;
    bit tx_idling = 1'b0;
    bit rx_idling = 1'b0;
    int rx_hold_cycles = 0;

    always #4ns aclk = ~aclk;

    rotary_encoder_key_events_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_counter_value (s_counter_value),
        .s_button_level  (s_button_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_code    (m_event_code)
    );

    // Work out the event of one tick and advance the predicted state.
    function automatic event_t predict_event(input logic [15:0] cnt, input logic lvl);
        logic [15:0] diff;
        int          delta;
        int          stride;
        event_t      ev;
        ev = EV_NONE;
        stride = (step_pulses == 8'd0) ? 1 : int'(step_pulses);
        // The first tick after reset only takes the baseline.
        if (!base_taken) begin
            base_count = cnt;
            base_taken = 1'b1;
            return EV_NONE;
        end
        diff  = cnt - base_count;
        delta = int'($signed(diff));
        if (delta >= stride) begin
            base_count = cnt;
            return EV_UP;
        end
        if (delta <= -stride) begin
            base_count = cnt;
            return EV_DOWN;
        end
        // No rotation: run the button machine, where level 0 means pressed.
        case (btn_phase)
            PH_IDLE: begin
                if (!lvl) btn_phase = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
                if (!lvl) begin
                    btn_phase  = PH_PRESSED;
                    hold_ticks = '0;
                end else begin
                    btn_phase = PH_IDLE;
                end
            end
            PH_PRESSED: begin
                if (!lvl) begin
                    hold_ticks = hold_ticks + 16'd1;
                    if (hold_ticks >= long_ticks) begin
                        ev        = EV_LONG;
                        btn_phase = PH_WAITREL;
                    end
                end else begin
                    ev        = EV_SHORT;
                    btn_phase = PH_IDLE;
                end
            end
            default: begin
                if (lvl) btn_phase = PH_IDLE;
            end
        endcase
        return ev;
    endfunction

    // Offer one tick and hold it until the block takes it.
    task automatic send_tick(input logic [15:0] cnt, input logic lvl);
        s_valid         <= 1'b1;
        s_counter_value <= cnt;
        s_button_level  <= lvl;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_events.push_back(predict_event(cnt, lvl));
    endtask

    // Random sender gap between ticks.
    task automatic maybe_gap();
        if (tx_idling && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every owed word has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both threshold registers back to back; the block must be idle.
    task automatic load_thresholds(input logic [15:0] step_word, input logic [15:0] hold_word);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_PULSES_PER_STEP;
        cfg_wr_data <= step_word;
        @(posedge aclk);
        step_pulses = step_word[7:0];
        cfg_index   <= CFG_LONG_PRESS_TICKS;
        cfg_wr_data <= hold_word;
        @(posedge aclk);
        long_ticks = hold_word;
        cfg_wr_en <= 1'b0;
    endtask

    // Mix of turning bursts, button presses with small jitter, and noise.
    task automatic scan_random_ticks(input int n);
        int          done;
        int          stride;
        int          kind;
        int          hold;
        logic [15:0] pos;
        done = 0;
        while (done < n) begin
            stride = (step_pulses == 8'd0) ? 1 : int'(step_pulses);
            kind   = $urandom_range(0, 9);
            if (kind < 4) begin
                // Turning: moves around the step size, button mostly released.
                repeat ($urandom_range(1, 6)) begin
                    pos = 16'(int'(base_count) + int'($urandom_range(0, 4 * stride))
                          - 2 * stride);
                    send_tick(pos, $urandom_range(0, 7) != 0);
                    maybe_gap();
                    done++;
                end
            end else if (kind < 8) begin
                // Press and release, with counter jitter below one step.
                hold = (long_ticks <= 16'd100) ? $urandom_range(1, int'(long_ticks) + 4)
                                               : $urandom_range(1, 30);
                repeat (hold + 2) begin
                    pos = 16'(int'(base_count) + int'($urandom_range(0, 2 * (stride - 1)))
                          - (stride - 1));
                    send_tick(pos, 1'b0);
                    maybe_gap();
                    done++;
                end
                repeat ($urandom_range(1, 2)) begin
                    pos = 16'(int'(base_count) + int'($urandom_range(0, 2 * (stride - 1)))
                          - (stride - 1));
                    send_tick(pos, 1'b1);
                    maybe_gap();
                    done++;
                end
            end else begin
                // Noise: any counter value and any level.
                repeat ($urandom_range(1, 4)) begin
                    send_tick(16'($urandom()), 1'($urandom()));
                    maybe_gap();
                    done++;
                end
            end
        end
    endtask

    // Baseline capture, wrap-around steps, debounce, presses, and the zero and largest settings.
    task automatic test_directed_ticks();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_tick(16'hFFFF, 1'b0);
        send_tick(16'h0002, 1'b1);
        send_tick(16'h0003, 1'b0);
        send_tick(16'hFFFF, 1'b0);
        send_tick(16'h7FFF, 1'b1);
        send_tick(16'hFFFE, 1'b1);
        send_tick(16'hFFFE, 1'b0);
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'hFFFD, 1'b0);
        send_tick(16'hFFFD, 1'b0);
        send_tick(16'hFFFD, 1'b0);
        send_tick(16'h0001, 1'b0);
        send_tick(16'h0002, 1'b0);
        send_tick(16'h0002, 1'b1);
        drain_results();
        // Zero step size acts as one, zero threshold gives a long press at once.
        load_thresholds(16'h0000, 16'h0000);
        send_tick(16'h0003, 1'b1);
        send_tick(16'h0003, 1'b0);
        send_tick(16'h0003, 1'b0);
        send_tick(16'h0003, 1'b0);
        send_tick(16'h0003, 1'b0);
        send_tick(16'h0003, 1'b1);
        drain_results();
        // Largest settings; the upper bits of the step word are dropped.
        load_thresholds(16'hFFFF, 16'hFFFF);
        send_tick(16'h0101, 1'b1);
        send_tick(16'h0102, 1'b1);
        send_tick(16'h0003, 1'b1);
        drain_results();
    endtask

    // Several settings, extremes first, each followed by random ticks.
    task automatic test_random_settings();
        logic [15:0] step_word;
        logic [15:0] hold_word;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin step_word = 16'd1;   hold_word = 16'd1;     end
                1: begin step_word = 16'd255; hold_word = 16'd65535; end
                2: begin step_word = 16'd4;   hold_word = 16'd75;    end
                3: begin step_word = 16'd0;   hold_word = 16'd0;     end
                4: begin
                    step_word = 16'($urandom());
                    hold_word = 16'($urandom());
                end
                default: begin
                    step_word = {8'($urandom()), 8'($urandom_range(1, 16))};
                    hold_word = 16'($urandom_range(1, 20));
                end
            endcase
            load_thresholds(step_word, hold_word);
            tx_idling = (ph % 3) != 2;
            rx_idling = (ph % 4) != 3;
            scan_random_ticks(110);
            drain_results();
        end
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        load_thresholds(16'd3, 16'd6);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        rx_hold_cycles = HOLD_OFF;
        scan_random_ticks(40);
        drain_results();
    endtask

    // Back-to-back ticks with both sides always ready.
    task automatic test_steady_stream();
        load_thresholds(16'd2, 16'd5);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        scan_random_ticks(80);
        drain_results();
    endtask

    // Receiver: long hold-offs on request, random stall bursts otherwise.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                while (rx_hold_cycles > 0) begin
                    @(posedge aclk);
                    rx_hold_cycles--;
                end
            end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each result word with the oldest owed event.
    always @(posedge aclk) begin : check_result
        event_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_events.size() == 0) begin
                $display("%0t: result word with nothing owed, got event_code %0d",
                         $time, m_event_code);
                errors++;
            end else begin
                want = expected_events.pop_front();
                if (m_event_code !== want) begin
                    $display("%0t: event_code mismatch, expected %0d (%s), got %0d",
                             $time, want, want.name(), m_event_code);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_PULSES_PER_STEP;
        cfg_wr_data     <= '0;
        s_valid         <= 1'b0;
        s_counter_value <= '0;
        s_button_level  <= 1'b1;
        base_count  = '0;
        base_taken  = 1'b0;
        btn_phase   = PH_IDLE;
        hold_ticks  = '0;
        step_pulses = 8'd4;
        long_ticks  = 16'd75;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ticks();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rek_pkg.sv
design/rek_step_detect.sv
design/rek_button_fsm.sv
design/rotary_encoder_key_events_core.sv
tb/tb.sv
